// File: rtl/core/ipv4_longest_prefix_match_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IPv4 longest prefix match core.
// Each macro expands to one labeled concurrent assertion on the core clock.
// ----------------------------------------------------------------------------
`ifndef IPV4_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LPM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpm assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define LPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpm assertion failed");

`endif

// File: rtl/core/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared constants, types and helper functions of the longest prefix match
// core: table size, entry layout and the nibble leading-ones count.
// ----------------------------------------------------------------------------
package lpm_pkg;

   // Number of route slots in the table.
   localparam int TABLE_ENTRIES = 16;

   // Address width of the table and width of the scan counter.
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Fixed field widths.
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int INDEX_W = 4;

   // Number of nibbles in a netmask, counted one per cycle.
   localparam int NIB_N = ADDR_W / 4;
   localparam int NIB_W = $clog2(NIB_N);

   // Item operation codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // One table entry as stored in the route memory.
   typedef struct packed {
      logic              valid;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] prefix;
   } entry_type;

   // Running best match of a lookup.
   typedef struct packed {
      logic             hit;
      logic [LEN_W-1:0] length;
   } best_type;

   // Count of leading one bits in a nibble, 0 to 4.
   function automatic logic [2:0] lead_ones4(input logic [3:0] nib);
      logic [2:0] n;
      n = 3'd0;
      if (nib[3]) begin
         n = 3'd1;
         if (nib[2]) begin
            n = 3'd2;
            if (nib[1]) begin
               n = 3'd3;
               if (nib[0]) begin
                  n = 3'd4;
               end
            end
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/core/ipv4_longest_prefix_match_core.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_core
// Routing table with longest prefix match lookup over TABLE_ENTRIES routes.
// ----------------------------------------------------------------------------
// The core takes one request word at a time. A write word counts the leading
// ones of the netmask one nibble per cycle and then stores the route. A
// lookup word reads the route memory one entry per cycle through its single
// registered read port and feeds each entry to one shared compare unit. After
// reset the core sweeps the memory once to clear every valid bit, and
// req_ready stays low during the sweep. A finished response sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match_core import lpm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [ADDR_W-1:0]  req_route_prefix,
   input  logic [ADDR_W-1:0]  req_route_mask,
   input  logic               req_entry_valid,
   input  logic [ADDR_W-1:0]  req_lookup_address,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [INDEX_W-1:0] rsp_match_index,
   output logic [LEN_W-1:0]   rsp_match_length
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_COUNT = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Route memory, written at one address and read at one address.
   entry_type mem [TABLE_ENTRIES];
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   entry_type         rd_data_ff;
   logic              rd_en;

   // Sequencer counters.
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [NIB_W-1:0]  nib_ff, nib_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   // Captured request word.
   logic [INDEX_W-1:0] idx_ff;
   logic [ADDR_W-1:0]  prefix_ff;
   logic [ADDR_W-1:0]  mask_ff, mask_in;
   logic               evalid_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               run_ff, run_in;

   // Working result.
   best_type           best_ff, best_in;
   logic [INDEX_W-1:0] bidx_ff, bidx_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic [LEN_W-1:0]   rsp_len_ff;

   logic               req_fire;
   logic               take;
   logic [LEN_W-1:0]   len_sum;
   logic [3:0]         nib_top;
   logic               slot_ok;
   logic               out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Leading-ones count of the current netmask nibble while the run lasts.
   assign nib_top = mask_ff[ADDR_W-1 -: 4];
   assign len_sum = best_ff.length + (run_ff ? LEN_W'(lead_ones4(nib_top)) : '0);
   assign slot_ok = 32'(idx_ff) < TABLE_ENTRIES;

   // Shared compare unit of the lookup scan.
   lpm_match_unit u_match (
      .address (addr_ff),
      .entry   (rd_data_ff),
      .best    (best_ff),
      .take    (take)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      nib_in       = nib_ff;
      mask_in      = mask_ff;
      run_in       = run_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      rd_en        = 1'b0;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               best_in = '0;
               nib_in  = '0;
               scan_in = '0;
               mask_in = req_route_mask;
               run_in  = 1'b1;
               if (req_op == OP_LOOKUP) begin
                  bidx_in  = '0;
                  state_in = S_SCAN;
               end else begin
                  bidx_in  = req_entry_index;
                  state_in = S_COUNT;
               end
            end
         end
         S_COUNT: begin
            best_in.length = len_sum;
            run_in  = run_ff && (nib_top == 4'hF);
            mask_in = mask_ff << 4;
            nib_in  = nib_ff + 1'b1;
            if (nib_ff == NIB_W'(NIB_N - 1)) begin
               wr_en         = slot_ok;
               wr_addr       = IDX_W'(idx_ff);
               wr_data.valid  = evalid_ff;
               wr_data.length = len_sum;
               wr_data.prefix = prefix_ff;
               state_in      = S_DONE;
            end
         end
         S_SCAN: begin
            // Issue the read of the next entry and judge the one read last cycle.
            if (scan_ff < CNT_W'(TABLE_ENTRIES)) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
            if (rd_vld_ff && take) begin
               best_in.hit    = 1'b1;
               best_in.length = rd_data_ff.length;
               bidx_in        = INDEX_W'(rd_idx_ff);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      nib_ff    <= nib_in;
      mask_ff   <= mask_in;
      run_ff    <= run_in;
      best_ff   <= best_in;
      bidx_ff   <= bidx_in;
      rd_idx_ff <= rd_idx_in;
      if (req_fire) begin
         idx_ff    <= req_entry_index;
         prefix_ff <= req_route_prefix;
         evalid_ff <= req_entry_valid;
         addr_ff   <= req_lookup_address;
      end
   end

   // Route memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

   // Output register, loaded when the finished word finds it free.
   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         rsp_hit_ff <= best_ff.hit;
         rsp_idx_ff <= bidx_ff;
         rsp_len_ff <= best_ff.length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_match_index  = rsp_idx_ff;
   assign rsp_match_length = rsp_len_ff;

endmodule

// File: rtl/core/lpm_match_unit.sv
// ----------------------------------------------------------------------------
// lpm_match_unit
// Shared compare unit of the lookup scan. It masks the address and the stored
// prefix to the entry's prefix length, compares them and decides whether the
// entry beats the best match found so far.
// ----------------------------------------------------------------------------
module lpm_match_unit import lpm_pkg::*; (
   input  logic [ADDR_W-1:0] address,
   input  entry_type         entry,
   input  best_type          best,
   output logic              take
);

   logic [ADDR_W-1:0] len_mask;
   logic              prefix_eq;

   // A length of zero gives an empty mask; 32 and above give a full mask.
   assign len_mask  = ~({ADDR_W{1'b1}} >> entry.length);
   assign prefix_eq = ((address ^ entry.prefix) & len_mask) == '0;

   // A longer match wins; on equal length the earlier entry stays.
   assign take = entry.valid && prefix_eq &&
                 (!best.hit || (entry.length > best.length));

endmodule

// File: rtl/core/lpm_checker.sv
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks of the longest prefix match core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ipv4_longest_prefix_match_core_macros.svh"

module lpm_checker import lpm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [INDEX_W-1:0] rsp_match_index,
   input logic [LEN_W-1:0]   rsp_match_length
);

   // A pending response word stays until it is taken.
   `LPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // The fields of a pending response word do not change while it waits.
   `LPM_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable({rsp_hit, rsp_match_index, rsp_match_length}))

   // One request word is worked on at a time.
   `LPM_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

   // A prefix length never exceeds the address width.
   `LPM_ASSERT_SAME(a_len_range, rsp_valid, rsp_match_length <= LEN_W'(ADDR_W))

endmodule

bind ipv4_longest_prefix_match_core lpm_checker u_lpm_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for ipv4_longest_prefix_match_core
// Drives route writes and address lookups through the request channel and
// checks every response word against a software model of the route table.
// The model tracks prefixes, lengths and active bits. It works out the
// longest match for each lookup in the order that words are accepted. The
// traffic runs in phases with different sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb import lpm_pkg::*;;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_WORDS = 332;

   // One request word and one response word as seen on the ports.
   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]  route_prefix;
      logic [ADDR_W-1:0]  route_mask;
      logic               entry_valid;
      logic [ADDR_W-1:0]  lookup_address;
   } route_word_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] match_index;
      logic [LEN_W-1:0]   match_length;
   } route_result_type;

   // Shadow route table and the queue of responses it predicts.
   class route_match_tracker;
      logic [ADDR_W-1:0] table_prefix [TABLE_ENTRIES];
      logic [LEN_W-1:0]  table_length [TABLE_ENTRIES];
      bit                table_active [TABLE_ENTRIES];
      route_result_type  pending_results [$];
      int                mismatches;

      function new();
         mismatches = 0;
         foreach (table_active[i]) begin
            table_active[i] = 1'b0;
         end
      endfunction

      // Mask with the top n bits set.
      function logic [ADDR_W-1:0] top_ones(int n);
         return (n == 0) ? '0 : ~({ADDR_W{1'b1}} >> n);
      endfunction

      // Length of the leading run of ones; bits after the first zero do not count.
      function logic [LEN_W-1:0] mask_length(logic [ADDR_W-1:0] mask);
         logic [LEN_W-1:0] n;
         bit               run;
         n = '0;
         run = 1'b1;
         for (int b = ADDR_W - 1; b >= 0; b--) begin
            run = run & mask[b];
            n = n + run;
         end
         return n;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      // Update the table for a write, or resolve the best route for a lookup.
      function void note_request(route_word_type w);
         route_result_type  r;
         logic [ADDR_W-1:0] keep;
         r = '0;
         if (w.op == OP_WRITE) begin
            r.match_index = w.entry_index;
            r.match_length = mask_length(w.route_mask);
            table_prefix[w.entry_index] = w.route_prefix;
            table_length[w.entry_index] = r.match_length;
            table_active[w.entry_index] = w.entry_valid;
         end else begin
            // Ascending scan with a strict compare keeps the lower slot on a tie.
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (table_active[i]) begin
                  keep = top_ones(table_length[i]);
                  if (((w.lookup_address ^ table_prefix[i]) & keep) == '0 &&
                      (!r.hit || table_length[i] > r.match_length)) begin
                     r.hit = 1'b1;
                     r.match_index = INDEX_W'(i);
                     r.match_length = table_length[i];
                  end
               end
            end
         end
         pending_results.push_back(r);
      endfunction

      // Compare one response word with the oldest prediction.
      task check_result(route_result_type got);
         route_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response word with no prediction pending");
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit)
               report_mismatch($sformatf("hit %b, predicted %b", got.hit, want.hit));
            if (got.match_index !== want.match_index)
               report_mismatch($sformatf("match_index %0d, predicted %0d",
                                         got.match_index, want.match_index));
            if (got.match_length !== want.match_length)
               report_mismatch($sformatf("match_length %0d, predicted %0d",
                                         got.match_length, want.match_length));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_op = OP_WRITE;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [ADDR_W-1:0]  req_route_prefix = '0;
   logic [ADDR_W-1:0]  req_route_mask = '0;
   logic               req_entry_valid = 1'b0;
   logic [ADDR_W-1:0]  req_lookup_address = '0;
   logic               rsp_ready = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [INDEX_W-1:0] rsp_match_index;
   logic [LEN_W-1:0]   rsp_match_length;

   route_match_tracker tracker = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // Prefixes and lengths last written per slot, used to aim lookups at routes.
   logic [ADDR_W-1:0] aim_prefix [TABLE_ENTRIES];
   logic [LEN_W-1:0]  aim_length [TABLE_ENTRIES];

   ipv4_longest_prefix_match_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_route_prefix   (req_route_prefix),
      .req_route_mask     (req_route_mask),
      .req_entry_valid    (req_entry_valid),
      .req_lookup_address (req_lookup_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_length   (rsp_match_length)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic route_word_type route_word(logic op, int idx, logic [ADDR_W-1:0] prefix,
                                                 logic [ADDR_W-1:0] mask, logic valid,
                                                 logic [ADDR_W-1:0] addr);
      route_word_type w;
      w.op = op;
      w.entry_index = INDEX_W'(idx);
      w.route_prefix = prefix;
      w.route_mask = mask;
      w.entry_valid = valid;
      w.lookup_address = addr;
      return w;
   endfunction

   // Offer one word after a random gap and hold it until it is taken.
   task automatic send_word(route_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= w.op;
      req_entry_index <= w.entry_index;
      req_route_prefix <= w.route_prefix;
      req_route_mask <= w.route_mask;
      req_entry_valid <= w.entry_valid;
      req_lookup_address <= w.lookup_address;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(w);
      if (w.op == OP_WRITE) begin
         aim_prefix[w.entry_index] = w.route_prefix;
         aim_length[w.entry_index] = tracker.mask_length(w.route_mask);
      end
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   // Random traffic: route writes and lookups, most lookups aimed at stored routes.
   task automatic run_phase(int words, int idle_pct, int stall_pct);
      route_word_type    w;
      int                len;
      int                slot;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] keep;
      logic [ADDR_W-1:0] addr;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (words) begin
         if ($urandom_range(99) < 35) begin
            // Default routes and host routes come up often; some masks have holes.
            case ($urandom_range(9))
               0: len = 0;
               1: len = ADDR_W;
               default: len = $urandom_range(ADDR_W - 1, 1);
            endcase
            mask = tracker.top_ones(len);
            if (len < ADDR_W && $urandom_range(9) == 0)
               mask = mask | ($urandom & ~tracker.top_ones(len + 1));
            w = route_word(OP_WRITE, $urandom_range(TABLE_ENTRIES - 1), $urandom, mask,
                           $urandom_range(99) < 85, $urandom);
         end else begin
            slot = $urandom_range(TABLE_ENTRIES - 1);
            keep = tracker.top_ones(aim_length[slot]);
            addr = $urandom;
            if ($urandom_range(9) < 7)
               addr = (aim_prefix[slot] & keep) | (addr & ~keep);
            w = route_word(OP_LOOKUP, $urandom_range(TABLE_ENTRIES - 1), $urandom, $urandom,
                           1'($urandom_range(1)), addr);
         end
         send_word(w);
      end
   endtask

   // Response side: check accepted words, then pick next cycle's ready.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            tracker.check_result({rsp_hit, rsp_match_index, rsp_match_length});
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("ipv4_longest_prefix_match_core verification failed");
      $finish;
   end

   initial begin
      foreach (aim_prefix[i]) begin
         aim_prefix[i] = '0;
         aim_length[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A lookup on the empty table misses.
      send_word(route_word(OP_LOOKUP, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0A00_0001));
      send_word(route_word(OP_WRITE, 0, 32'h0A00_0000, 32'hFF00_0000, 1'b1, 32'hFFFF_FFFF));
      send_word(route_word(OP_WRITE, 15, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1, 32'h0));
      send_word(route_word(OP_WRITE, 7, 32'hC0A8_0155, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678));
      // Default route; its prefix bits are all ignored.
      send_word(route_word(OP_WRITE, 3, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1, 32'h0));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'hC0A8_0155));
      send_word(route_word(OP_LOOKUP, 15, 32'h0, 32'h0, 1'b0, 32'hC0A8_01FE));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h0A12_3456));
      send_word(route_word(OP_LOOKUP, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h7F00_0001));
      // Mask with a hole counts only its leading ones; low prefix bits are ignored.
      send_word(route_word(OP_WRITE, 1, 32'h0AFF_FFFF, 32'hFF00_FF00, 1'b1, 32'h0));
      // Two routes of equal length match; the lower slot wins.
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h0A00_0001));
      // Clearing the valid bit removes a slot.
      send_word(route_word(OP_WRITE, 0, 32'h0A00_0000, 32'hFF00_0000, 1'b0, 32'h0));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h0A00_0001));
      send_word(route_word(OP_WRITE, 3, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h7F00_0001));
      send_word(route_word(OP_WRITE, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFE));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h0000_0000));
      // Mask whose top bit is zero gives a default route.
      send_word(route_word(OP_WRITE, 4, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'h0000_0000));
      send_word(route_word(OP_LOOKUP, 0, 32'h0, 32'h0, 1'b0, 32'hC0A8_0155));
      wait_for_drain();

      // Unthrottled traffic, opened by a long receiver hold-off that backs up the core.
      hold_left = 300;
      run_phase(PHASE_WORDS, 0, 0);
      wait_for_drain();
      run_phase(PHASE_WORDS, 69, 0);
      wait_for_drain();
      run_phase(PHASE_WORDS, 0, 69);
      wait_for_drain();
      run_phase(PHASE_WORDS, 22, 22);
      wait_for_drain();

      repeat (40) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report_mismatch("predicted responses left over at end");
      if (tracker.mismatches == 0) begin
         $display("ipv4_longest_prefix_match_core verification clean");
      end else begin
         $display("ipv4_longest_prefix_match_core verification failed");
      end
      $finish;
   end

endmodule

// File: ipv4_longest_prefix_match_core.f
+incdir+rtl/core
rtl/core/lpm_pkg.sv
rtl/core/lpm_match_unit.sv
rtl/core/ipv4_longest_prefix_match_core.sv
rtl/core/lpm_checker.sv
tb/sv/tb.sv
